>>> rtl/msc_pkg.sv
// msc_pkg: types, codes and constants of the masked byte pattern scanner
// used by msc_cell, msc_pat_mem and masked_byte_pattern_scanner
// no dependencies
package msc_pkg;

  // default depth of the pattern and of the byte window
  localparam int PatternMaxDef = 64;
  // number of bytes in an embedded reference word
  localparam int RefBytes = 4;
  // width of the configuration register index
  localparam int CfgIdxW = 3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_LENGTH  = 3'd0,
    CFG_HAS_REFERENCE   = 3'd1,
    CFG_REFERENCE_START = 3'd2,
    CFG_REFERENCE_SIZE  = 3'd3,
    CFG_ADD_OFFSET      = 3'd4,
    CFG_MODULE_BASE     = 3'd5
  } cfg_idx_e;

  // input item actions
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_SCAN = 1'b1
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    STS_FOUND     = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_BAD_REF   = 2'd2
  } status_e;

  // control states of the scanner
  typedef enum logic [1:0] {
    MS_IDLE,
    MS_FILL,
    MS_RESULT
  } state_e;

  typedef struct packed {
    logic       action;
    logic [5:0] entry_index;
    logic [7:0] entry_byte;
    logic       entry_care;
    logic [7:0] image_byte;
    logic       image_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_value;
    logic [31:0] match_position;
  } out_item_t;

  // one pattern position: care bit and byte
  typedef struct packed {
    logic       care;
    logic [7:0] val;
  } pat_ent_t;

  // per-cell controls
  typedef struct packed {
    logic shift_win;
    logic shift_pat;
    logic load_pat;
  } cell_ctl_t;

endpackage

>>> rtl/msc_pat_mem.sv
// msc_pat_mem: pattern entry store, one write port and one registered read port
// entries never written read with care 0
// depends on msc_pkg
module msc_pat_mem #(
  parameter int PATTERN_MAX = msc_pkg::PatternMaxDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [$clog2(PATTERN_MAX)-1:0] waddr_i,
  input  msc_pkg::pat_ent_t              wdata_i,
  input  logic [$clog2(PATTERN_MAX)-1:0] raddr_i,
  output msc_pkg::pat_ent_t              rdata_o
);

  msc_pkg::pat_ent_t       mem_q [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]  valid_q;
  msc_pkg::pat_ent_t       rd_q;
  logic                    rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o.care = rd_q.care & rd_valid_q;
  assign rdata_o.val  = rd_q.val;

endmodule

>>> rtl/msc_cell.sv
// msc_cell: one position of the scan chain
// holds one window byte and one aligned pattern entry, compares them
// depends on msc_pkg
module msc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  msc_pkg::cell_ctl_t  ctl_i,
  input  logic [7:0]          byte_i,
  input  msc_pkg::pat_ent_t   ent_i,
  input  msc_pkg::pat_ent_t   ld_i,
  output logic [7:0]          byte_o,
  output msc_pkg::pat_ent_t   ent_o,
  output logic                ok_o
);

  logic [7:0] win_q;
  logic [7:0] val_q;
  logic       care_q;

  // window byte moves one cell along per scanned byte while shift_win is set
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift_win) begin
      win_q <= byte_i;
    end
    if (ctl_i.shift_pat) begin
      val_q <= ent_i.val;
    end else if (ctl_i.load_pat) begin
      val_q <= ld_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      care_q <= 1'b0;
    end else if (ctl_i.shift_pat) begin
      care_q <= ent_i.care;
    end else if (ctl_i.load_pat) begin
      care_q <= ld_i.care;
    end
  end

  assign byte_o     = win_q;
  assign ent_o.care = care_q;
  assign ent_o.val  = val_q;
  // compare against the byte entering this cell, i.e. the window after the shift
  assign ok_o       = ~care_q | (val_q == byte_i);

endmodule

>>> rtl/masked_byte_pattern_scanner.sv
// masked_byte_pattern_scanner: top level of the masked byte pattern scanner
// a chain of msc_cell compares the byte window with an aligned copy of the pattern
// depends on msc_pkg, msc_cell, msc_pat_mem
//
//   channel  direction  handshake                  payload
//   in       in         in_valid_i / in_stall_o    msc_pkg::in_item_t
//   out      out        out_valid_o / out_stall_i  msc_pkg::out_item_t
//   cfg      in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// loads and scanned bytes are taken only while idle; a byte that ends in a result
// moves the scanner to the result state, where the reference word and sums are formed
// a write of pattern_length realigns the pattern chain through the single read port
// of the pattern store, input stalled meanwhile
// reset clears control registers, counters and care bits; no realign is needed after it
// one finished result waits in the output register without holding up input
module masked_byte_pattern_scanner #(
  parameter int PATTERN_MAX = msc_pkg::PatternMaxDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  msc_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output msc_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [msc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam int IW = $clog2(PATTERN_MAX);       // cell index width
  localparam int CW = $clog2(PATTERN_MAX + 1);   // counts up to PATTERN_MAX
  localparam int XW = (CW > 7) ? CW : 7;         // compare width for lengths
  localparam logic [XW-1:0] MaxX = XW'(PATTERN_MAX);

  // configuration registers
  logic [6:0]  pat_len_q;
  logic        has_ref_q;
  logic [5:0]  ref_start_q;
  logic [6:0]  ref_size_q;
  logic [31:0] add_off_q;
  logic [31:0] mod_base_q;

  // control state
  msc_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            blank_q;
  logic [31:0]     seen_q, seen_d;
  logic            done_q, done_d;
  logic            pend_found_q, pend_found_d;
  logic [31:0]     pend_pos_q, pend_pos_d;
  logic            out_valid_q, out_valid_d;
  msc_pkg::out_item_t out_q, out_d;

  // chain wiring
  logic [7:0]          win_w  [PATTERN_MAX];
  msc_pkg::pat_ent_t   ent_w  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] ok_w;
  msc_pkg::cell_ctl_t  ctl_w  [PATTERN_MAX];
  msc_pkg::pat_ent_t   ld_ent;
  msc_pkg::pat_ent_t   rd_ent;
  msc_pkg::pat_ent_t   fill_ent;

  // input decode
  logic            in_acc;
  logic            is_load;
  logic            is_scan;
  logic [XW-1:0]   n_x;
  logic [XW-1:0]   idx_x;
  logic            len_ok;
  logic            mem_we;
  logic            ld_any;
  logic [XW-1:0]   ld_tgt;
  logic            shift_win;
  logic            shift_pat;
  logic            match;
  logic [31:0]     seen_inc;
  logic            out_free;

  // realign read addressing
  logic [XW-1:0]   lead;
  logic [XW-1:0]   rd_off;
  logic            blank_d;

  // result forming
  logic [31:0]     ref_word;
  logic [31:0]     res_val;
  logic [1:0]      res_sts;

  assign cfg_ready_o = 1'b1;

  assign n_x     = XW'(pat_len_q);
  assign idx_x   = XW'(in_data_i.entry_index);
  assign len_ok  = (n_x != '0) && (n_x <= MaxX);
  assign in_stall_o = (state_q != msc_pkg::MS_IDLE);
  assign in_acc  = in_valid_i & ~in_stall_o;
  assign is_load = in_acc & (in_data_i.action == msc_pkg::ACT_LOAD);
  assign is_scan = in_acc & (in_data_i.action == msc_pkg::ACT_SCAN);

  // load transactions write the store and, inside the used length, the aligned copy
  assign mem_we  = is_load & (idx_x < MaxX);
  assign ld_any  = is_load & len_ok & (idx_x < n_x);
  assign ld_tgt  = n_x - XW'(1) - idx_x;
  assign ld_ent.care = in_data_i.entry_care;
  assign ld_ent.val  = in_data_i.entry_byte;

  // window only moves while a scan is still looking
  assign shift_win = is_scan & ~done_q;
  assign shift_pat = (state_q == msc_pkg::MS_FILL) && (cnt_q != '0);
  assign seen_inc  = seen_q + 32'd1;
  assign match     = shift_win & len_ok & (&ok_w) & (seen_inc >= 32'(pat_len_q));

  // realign: step m reads pattern index m - (PATTERN_MAX - n), leading steps are blank
  assign lead    = MaxX - n_x;
  assign rd_off  = XW'(cnt_q) - lead;
  assign blank_d = ~len_ok | (XW'(cnt_q) < lead);
  assign fill_ent.care = blank_q ? 1'b0 : rd_ent.care;
  assign fill_ent.val  = rd_ent.val;

  msc_pat_mem #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_pat_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (idx_x[IW-1:0]),
    .wdata_i (ld_ent),
    .raddr_i (rd_off[IW-1:0]),
    .rdata_o (rd_ent)
  );

  // cell k holds window byte k (newest first) and pattern entry n-1-k
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    assign ctl_w[k].shift_win = shift_win;
    assign ctl_w[k].shift_pat = shift_pat;
    assign ctl_w[k].load_pat  = ld_any & (ld_tgt[IW-1:0] == IW'(k));

    if (k == 0) begin : g_head
      msc_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl_w[k]),
        .byte_i (in_data_i.image_byte),
        .ent_i  (fill_ent),
        .ld_i   (ld_ent),
        .byte_o (win_w[k]),
        .ent_o  (ent_w[k]),
        .ok_o   (ok_w[k])
      );
    end else begin : g_body
      msc_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl_w[k]),
        .byte_i (win_w[k-1]),
        .ent_i  (ent_w[k-1]),
        .ld_i   (ld_ent),
        .byte_o (win_w[k]),
        .ent_o  (ent_w[k]),
        .ok_o   (ok_w[k])
      );
    end
  end

  // reference word: pattern index j sits in window cell n-1-j; beyond the length reads zero
  always_comb begin
    logic [XW-1:0] j;
    logic [XW-1:0] w;
    ref_word = '0;
    for (int k = 0; k < msc_pkg::RefBytes; k++) begin
      j = XW'(ref_start_q) + XW'(k);
      w = n_x - XW'(1) - j;
      if (j < n_x) begin
        ref_word[8*k +: 8] = win_w[w[IW-1:0]];
      end
    end
  end

  // result fields for a pending match
  always_comb begin
    res_sts = msc_pkg::STS_FOUND;
    res_val = mod_base_q + pend_pos_q + add_off_q;
    if (has_ref_q) begin
      if (ref_size_q != 7'(msc_pkg::RefBytes)) begin
        res_sts = msc_pkg::STS_BAD_REF;
        res_val = '0;
      end else begin
        res_val = ref_word + add_off_q;
      end
    end
  end

  assign out_free = ~out_valid_q | ~out_stall_i;

  // next state and datapath controls
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    seen_d       = seen_q;
    done_d       = done_q;
    pend_found_d = pend_found_q;
    pend_pos_d   = pend_pos_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_d        = out_q;

    case (state_q)
      msc_pkg::MS_IDLE: begin
        if (shift_win) begin
          seen_d = seen_inc;
          if (match) begin
            // first match of this image
            pend_found_d = 1'b1;
            pend_pos_d   = seen_inc - 32'(pat_len_q);
            done_d       = 1'b1;
            state_d      = msc_pkg::MS_RESULT;
          end else if (in_data_i.image_last) begin
            // image ended without a match
            pend_found_d = 1'b0;
            pend_pos_d   = '0;
            state_d      = msc_pkg::MS_RESULT;
          end
        end
        if (is_scan & in_data_i.image_last) begin
          seen_d = '0;
          done_d = 1'b0;
        end
      end
      msc_pkg::MS_FILL: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(PATTERN_MAX)) begin
          state_d = msc_pkg::MS_IDLE;
        end
      end
      msc_pkg::MS_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (pend_found_q) begin
            out_d.status         = res_sts;
            out_d.result_value   = res_val;
            out_d.match_position = pend_pos_q;
          end else begin
            out_d.status         = msc_pkg::STS_NOT_FOUND;
            out_d.result_value   = '0;
            out_d.match_position = '0;
          end
          state_d = msc_pkg::MS_IDLE;
        end
      end
      default: begin
        state_d = msc_pkg::MS_IDLE;
      end
    endcase

    // a new pattern length restarts the realign pass
    if (cfg_valid_i &&
        (msc_pkg::cfg_idx_e'(cfg_index_i) == msc_pkg::CFG_PATTERN_LENGTH)) begin
      state_d = msc_pkg::MS_FILL;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= msc_pkg::MS_IDLE;
      cnt_q        <= '0;
      blank_q      <= 1'b1;
      seen_q       <= '0;
      done_q       <= 1'b0;
      pend_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      blank_q      <= blank_d;
      seen_q       <= seen_d;
      done_q       <= done_d;
      pend_found_q <= pend_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_pos_q <= pend_pos_d;
    out_q      <= out_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= '0;
      has_ref_q   <= 1'b0;
      ref_start_q <= '0;
      ref_size_q  <= '0;
      add_off_q   <= '0;
      mod_base_q  <= '0;
    end else if (cfg_valid_i) begin
      case (msc_pkg::cfg_idx_e'(cfg_index_i))
        msc_pkg::CFG_PATTERN_LENGTH:  pat_len_q   <= cfg_data_i[6:0];
        msc_pkg::CFG_HAS_REFERENCE:   has_ref_q   <= cfg_data_i[0];
        msc_pkg::CFG_REFERENCE_START: ref_start_q <= cfg_data_i[5:0];
        msc_pkg::CFG_REFERENCE_SIZE:  ref_size_q  <= cfg_data_i[6:0];
        msc_pkg::CFG_ADD_OFFSET:      add_off_q   <= cfg_data_i;
        msc_pkg::CFG_MODULE_BASE:     mod_base_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
